>>> design/pvp_pkg.sv
// ----------------------------------------------------------------------------
// pvp_pkg
// Shared widths, payload structs and register codes for the perspective
// vertex projection core.
// ----------------------------------------------------------------------------
package pvp_pkg;

  localparam int WORD_BITS = 24;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SUM_BITS  = ((2 * WORD_BITS > WORD_BITS + FRAC_BITS) ?
                              2 * WORD_BITS : WORD_BITS + FRAC_BITS) + 1;
  localparam int CELL_COUNT = WORD_BITS;
  localparam int LATENCY    = CELL_COUNT + 3;
  localparam int INDEX_BITS = 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0] mag_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SUM_BITS-1:0] sum_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t ONE_FIX  = word_t'(64'd1 << FRAC_BITS);

  typedef enum logic [INDEX_BITS-1:0] {
    REG_X_GAIN   = 2'd0,
    REG_Y_GAIN   = 2'd1,
    REG_Z_SCALE  = 2'd2,
    REG_Z_OFFSET = 2'd3
  } reg_idx_t;

  typedef struct packed {
    word_t in_x;
    word_t in_y;
    word_t in_z;
  } item_t;

  typedef struct packed {
    word_t proj_x;
    word_t proj_y;
    word_t depth;
    logic  w_zero;
  } result_t;

  typedef struct packed {
    word_t x_gain;
    word_t y_gain;
    word_t z_scale;
    word_t z_offset;
  } cfg_t;

  typedef struct packed {
    mag_t rem;
    mag_t num;
    mag_t den;
    mag_t quo;
    logic neg;
    logic ovf;
  } lane_t;

  typedef struct packed {
    word_t sh_x;
    word_t sh_y;
    word_t depth;
    logic  w_zero;
  } side_t;

  typedef struct packed {
    lane_t lx;
    lane_t ly;
    side_t side;
  } stage_t;

endpackage

>>> design/pvp_front.sv
// ----------------------------------------------------------------------------
// pvp_front
// Multiply stage and divider setup stage: products, rounded shifts for the
// depth and undivided paths, dividend and divisor magnitudes, overflow check.
// ----------------------------------------------------------------------------
module pvp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  pvp_pkg::item_t   item,
  input  pvp_pkg::cfg_t    cfg,
  output logic             out_valid,
  output pvp_pkg::stage_t  out_stage
);

  localparam logic [pvp_pkg::SUM_BITS:0] HALF_R =
    (pvp_pkg::SUM_BITS+1)'(1) << (pvp_pkg::FRAC_BITS - 1);

  function automatic pvp_pkg::word_t round_shift_sat(input pvp_pkg::sum_t v);
    logic                        neg;
    logic [pvp_pkg::SUM_BITS-1:0] m;
    logic [pvp_pkg::SUM_BITS:0]   r;
    pvp_pkg::word_t              res;
    neg = v[pvp_pkg::SUM_BITS-1];
    m = v;
    if (neg) begin
      m = -m;
    end
    r = ({1'b0, m} + HALF_R) >> pvp_pkg::FRAC_BITS;
    if (!neg) begin
      res = (|r[pvp_pkg::SUM_BITS:pvp_pkg::WORD_BITS-1]) ? pvp_pkg::WORD_MAX :
            pvp_pkg::word_t'(r[pvp_pkg::WORD_BITS-1:0]);
    end else begin
      res = ((|r[pvp_pkg::SUM_BITS:pvp_pkg::WORD_BITS]) ||
             (r[pvp_pkg::WORD_BITS-1] && (|r[pvp_pkg::WORD_BITS-2:0]))) ?
            pvp_pkg::WORD_MIN : pvp_pkg::word_t'(-r[pvp_pkg::WORD_BITS-1:0]);
    end
    return res;
  endfunction

  function automatic pvp_pkg::lane_t lane_prep(input pvp_pkg::prod_t prod,
                                               input pvp_pkg::mag_t  den,
                                               input logic           den_neg);
    logic [pvp_pkg::PROD_BITS-1:0] un;
    logic [pvp_pkg::PROD_BITS-1:0] np;
    pvp_pkg::lane_t                l;
    un = prod;
    if (prod[pvp_pkg::PROD_BITS-1]) begin
      un = -un;
    end
    np = un + pvp_pkg::PROD_BITS'(den >> 1);
    l.rem = np[pvp_pkg::PROD_BITS-1:pvp_pkg::WORD_BITS];
    l.num = np[pvp_pkg::WORD_BITS-1:0];
    l.den = den;
    l.quo = '0;
    l.neg = prod[pvp_pkg::PROD_BITS-1] ^ den_neg;
    l.ovf = (np[pvp_pkg::PROD_BITS-1:pvp_pkg::WORD_BITS] >= den);
    return l;
  endfunction

  logic             v1;
  pvp_pkg::prod_t   px;
  pvp_pkg::prod_t   py;
  pvp_pkg::prod_t   pz;
  pvp_pkg::word_t   zo;
  pvp_pkg::word_t   z;

  logic             z_neg;
  pvp_pkg::mag_t    z_mag;
  pvp_pkg::sum_t    depth_sum;
  pvp_pkg::stage_t  out_stage_next;

  always_comb begin
    z_neg = z[pvp_pkg::WORD_BITS-1];
    z_mag = z_neg ? pvp_pkg::mag_t'(-z) : pvp_pkg::mag_t'(z);
    depth_sum = pvp_pkg::SUM_BITS'(pz) + (pvp_pkg::SUM_BITS'(zo) <<< pvp_pkg::FRAC_BITS);
    out_stage_next.lx = lane_prep(px, z_mag, z_neg);
    out_stage_next.ly = lane_prep(py, z_mag, z_neg);
    out_stage_next.side.sh_x   = round_shift_sat(pvp_pkg::SUM_BITS'(px));
    out_stage_next.side.sh_y   = round_shift_sat(pvp_pkg::SUM_BITS'(py));
    out_stage_next.side.depth  = round_shift_sat(depth_sum);
    out_stage_next.side.w_zero = (z == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= take;
      out_valid <= v1;
    end
    px <= pvp_pkg::PROD_BITS'(item.in_x) * pvp_pkg::PROD_BITS'(cfg.x_gain);
    py <= pvp_pkg::PROD_BITS'(item.in_y) * pvp_pkg::PROD_BITS'(cfg.y_gain);
    pz <= pvp_pkg::PROD_BITS'(item.in_z) * pvp_pkg::PROD_BITS'(cfg.z_scale);
    zo <= cfg.z_offset;
    z  <= item.in_z;
    out_stage <= out_stage_next;
  end

endmodule

>>> design/pvp_cell.sv
// ----------------------------------------------------------------------------
// pvp_cell
// One divider cell: a restoring compare-subtract step on the x and y lanes,
// yielding one quotient bit each, with the side payload carried along.
// ----------------------------------------------------------------------------
module pvp_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  pvp_pkg::stage_t  in_stage,
  output logic             out_valid,
  output pvp_pkg::stage_t  out_stage
);

  function automatic pvp_pkg::lane_t lane_step(input pvp_pkg::lane_t l);
    logic [pvp_pkg::WORD_BITS:0] t;
    logic [pvp_pkg::WORD_BITS:0] d;
    logic                        ge;
    pvp_pkg::lane_t              n;
    n  = l;
    t  = {l.rem, l.num[pvp_pkg::WORD_BITS-1]};
    d  = t - {1'b0, l.den};
    ge = (t >= {1'b0, l.den});
    n.rem = ge ? d[pvp_pkg::WORD_BITS-1:0] : t[pvp_pkg::WORD_BITS-1:0];
    n.num = {l.num[pvp_pkg::WORD_BITS-2:0], 1'b0};
    n.quo = {l.quo[pvp_pkg::WORD_BITS-2:0], ge};
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_stage.lx   <= lane_step(in_stage.lx);
    out_stage.ly   <= lane_step(in_stage.ly);
    out_stage.side <= in_stage.side;
  end

endmodule

>>> design/perspective_vertex_project_core.sv
// ----------------------------------------------------------------------------
// perspective_vertex_project_core
// Perspective projection of one Q8.16 vertex per clock: x and y scaled by
// their gains and divided by w = z, or left undivided when z is zero.
// ----------------------------------------------------------------------------
// Depth is scaled and offset, and all outputs saturate. Takes one vertex per
// clock with start; busy is high only during reset. Each result appears on
// result with done high for exactly one cycle, in order; the receiver cannot
// stall it and must take it then. The pipeline is a multiply stage, a divider
// setup stage, a row of 24 divider cells that each settle one quotient bit
// of x/w and y/w, and the output register. Register writes on the cfg channel
// are always ready and take effect on the next cycle; write them only while
// no vertex is in flight.
module perspective_vertex_project_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  pvp_pkg::item_t                     item,
  output logic                               done,
  output pvp_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pvp_pkg::INDEX_BITS-1:0]     cfg_index,
  input  pvp_pkg::word_t                     cfg_data
);

  function automatic pvp_pkg::word_t sat_quot(input pvp_pkg::lane_t l);
    pvp_pkg::word_t res;
    if (l.ovf) begin
      res = l.neg ? pvp_pkg::WORD_MIN : pvp_pkg::WORD_MAX;
    end else if (!l.neg) begin
      res = l.quo[pvp_pkg::WORD_BITS-1] ? pvp_pkg::WORD_MAX : pvp_pkg::word_t'(l.quo);
    end else begin
      res = (l.quo[pvp_pkg::WORD_BITS-1] && (|l.quo[pvp_pkg::WORD_BITS-2:0])) ?
            pvp_pkg::WORD_MIN : pvp_pkg::word_t'(-l.quo);
    end
    return res;
  endfunction

  pvp_pkg::cfg_t     cfg;
  logic              take;
  logic              chain_valid [0:pvp_pkg::CELL_COUNT];
  pvp_pkg::stage_t   chain_stage [0:pvp_pkg::CELL_COUNT];
  pvp_pkg::stage_t   last;
  pvp_pkg::result_t  result_next;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_gain   <= pvp_pkg::ONE_FIX;
      cfg.y_gain   <= pvp_pkg::ONE_FIX;
      cfg.z_scale  <= pvp_pkg::ONE_FIX;
      cfg.z_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pvp_pkg::reg_idx_t'(cfg_index))
        pvp_pkg::REG_X_GAIN:   cfg.x_gain   <= cfg_data;
        pvp_pkg::REG_Y_GAIN:   cfg.y_gain   <= cfg_data;
        pvp_pkg::REG_Z_SCALE:  cfg.z_scale  <= cfg_data;
        pvp_pkg::REG_Z_OFFSET: cfg.z_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  pvp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (item),
    .cfg       (cfg),
    .out_valid (chain_valid[0]),
    .out_stage (chain_stage[0])
  );

  for (genvar i = 0; i < pvp_pkg::CELL_COUNT; i++) begin : g_cell
    pvp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_stage  (chain_stage[i]),
      .out_valid (chain_valid[i+1]),
      .out_stage (chain_stage[i+1])
    );
  end

  always_comb begin
    last = chain_stage[pvp_pkg::CELL_COUNT];
    result_next.w_zero = last.side.w_zero;
    result_next.depth  = last.side.depth;
    result_next.proj_x = last.side.w_zero ? last.side.sh_x : sat_quot(last.lx);
    result_next.proj_y = last.side.w_zero ? last.side.sh_y : sat_quot(last.ly);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain_valid[pvp_pkg::CELL_COUNT];
    end
    result <= result_next;
  end

endmodule

>>> design/pvp_checker.sv
// ----------------------------------------------------------------------------
// pvp_checker
// Port-level checks on the projection core: fixed latency in both
// directions and the w-zero flag against the vertex that caused it.
// ----------------------------------------------------------------------------
module pvp_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  pvp_pkg::item_t    item,
  input  logic              done,
  input  pvp_pkg::result_t  result
);

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(pvp_pkg::LATENCY) done)
    else $error("transfer accepted without result at fixed latency");

  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, pvp_pkg::LATENCY))
    else $error("result without an accepted transfer");

  a_w_zero_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.w_zero == ($past(item.in_z, pvp_pkg::LATENCY) == '0)))
    else $error("w_zero does not match the vertex z");

endmodule

bind perspective_vertex_project_core pvp_checker u_pvp_checker (.*);

>>> tb/perspective_vertex_project_core_tb.sv
// ----------------------------------------------------------------------------
// perspective_vertex_project_core_tb
// Self-checking bench for the perspective vertex projection core. A short
// table of directed vertices runs under reset settings, then random vertices
// run under a series of register settings, extremes included, with the
// sender idling at several rates. Every result is checked field by field
// against the bench's fixed-point model or a value typed into the table.
// ----------------------------------------------------------------------------
module perspective_vertex_project_core_tb;

  localparam int ONE_Q = 1 << pvp_pkg::FRAC_BITS;
  localparam longint unsigned POS_LIMIT = (64'd1 << (pvp_pkg::WORD_BITS - 1)) - 1;
  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_PER_SETTING = 93;

  typedef struct {
    pvp_pkg::item_t   vertex;
    bit               typed;
    pvp_pkg::result_t want;
  } directed_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  pvp_pkg::item_t                 item = '0;
  logic                           done;
  pvp_pkg::result_t               result;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pvp_pkg::INDEX_BITS-1:0] cfg_index = '0;
  pvp_pkg::word_t                 cfg_data = '0;

  pvp_pkg::cfg_t    regs_now;
  pvp_pkg::result_t pending_projections[$];
  pvp_pkg::result_t want_now;
  int      mismatch_count = 0;
  int      results_seen = 0;
  int      w_zero_seen = 0;
  int      vertices_sent = 0;
  int      settings_used = 0;
  int      cycle_count = 0;
  int      idle_pct = 0;

  perspective_vertex_project_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic pvp_pkg::word_t round_sat(longint num, longint den);
    bit neg;
    longint unsigned un;
    longint unsigned ud;
    longint unsigned q;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (un + ud / 2) / ud;
    if (!neg) return (q > POS_LIMIT) ? pvp_pkg::WORD_MAX : pvp_pkg::word_t'(q);
    return (q > POS_LIMIT + 1) ? pvp_pkg::WORD_MIN : pvp_pkg::word_t'(-q);
  endfunction

  function automatic pvp_pkg::result_t project_vertex(pvp_pkg::item_t v);
    longint x;
    longint y;
    longint z;
    longint px;
    longint py;
    longint pd;
    pvp_pkg::result_t r;
    x = longint'(v.in_x);
    y = longint'(v.in_y);
    z = longint'(v.in_z);
    px = x * longint'(regs_now.x_gain);
    py = y * longint'(regs_now.y_gain);
    pd = z * longint'(regs_now.z_scale) + longint'(regs_now.z_offset) * longint'(ONE_Q);
    r.w_zero = (z == 0);
    r.proj_x = round_sat(px, r.w_zero ? longint'(ONE_Q) : z);
    r.proj_y = round_sat(py, r.w_zero ? longint'(ONE_Q) : z);
    r.depth  = round_sat(pd, longint'(ONE_Q));
    return r;
  endfunction

  function automatic pvp_pkg::word_t rand_word();
    case ($urandom_range(0, 9))
      0: return pvp_pkg::WORD_MAX;
      1: return pvp_pkg::WORD_MIN;
      2: return '0;
      3: return $urandom_range(0, 1) ? pvp_pkg::word_t'(1) : pvp_pkg::word_t'(-1);
      4, 5, 6: return pvp_pkg::word_t'(int'($urandom_range(0, 8 * ONE_Q)) - 4 * ONE_Q);
      default: return pvp_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic signed [63:0] got,
                             logic signed [63:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (result.w_zero) w_zero_seen++;
      if (pending_projections.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: x=%0d y=%0d d=%0d wz=%0b",
                                result.proj_x, result.proj_y, result.depth,
                                result.w_zero));
      end else begin
        want_now = pending_projections.pop_front();
        check_field("proj_x", 64'(result.proj_x), 64'(want_now.proj_x));
        check_field("proj_y", 64'(result.proj_y), 64'(want_now.proj_y));
        check_field("depth", 64'(result.depth), 64'(want_now.depth));
        check_field("w_zero", 64'(result.w_zero), 64'(want_now.w_zero));
      end
    end
  end

  // Hold start across back-to-back vertices; drop it only for an idle gap.
  task automatic drive_vertex(pvp_pkg::item_t v, pvp_pkg::result_t want);
    start <= 1'b1;
    item <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_projections.push_back(want);
    vertices_sent++;
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_projections.size() != 0) @(posedge clk);
  endtask

  task automatic load_setting(pvp_pkg::cfg_t s);
    pvp_pkg::reg_idx_t order[4];
    pvp_pkg::word_t val;
    order = '{pvp_pkg::REG_X_GAIN, pvp_pkg::REG_Y_GAIN, pvp_pkg::REG_Z_SCALE,
              pvp_pkg::REG_Z_OFFSET};
    foreach (order[i]) begin
      case (order[i])
        pvp_pkg::REG_X_GAIN:  val = s.x_gain;
        pvp_pkg::REG_Y_GAIN:  val = s.y_gain;
        pvp_pkg::REG_Z_SCALE: val = s.z_scale;
        default:              val = s.z_offset;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data <= val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (order[i])
        pvp_pkg::REG_X_GAIN:  regs_now.x_gain = val;
        pvp_pkg::REG_Y_GAIN:  regs_now.y_gain = val;
        pvp_pkg::REG_Z_SCALE: regs_now.z_scale = val;
        default:              regs_now.z_offset = val;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    directed_row_t rows[$];
    pvp_pkg::cfg_t settings[$];
    pvp_pkg::item_t v;
    regs_now = '{pvp_pkg::ONE_FIX, pvp_pkg::ONE_FIX, pvp_pkg::ONE_FIX, '0};

    rows.push_back('{'{pvp_pkg::ONE_FIX, pvp_pkg::ONE_FIX, pvp_pkg::ONE_FIX}, 1'b1,
                     '{pvp_pkg::ONE_FIX, pvp_pkg::ONE_FIX, pvp_pkg::ONE_FIX, 1'b0}});
    rows.push_back('{'{pvp_pkg::word_t'(100), pvp_pkg::word_t'(-100), '0}, 1'b1,
                     '{pvp_pkg::word_t'(100), pvp_pkg::word_t'(-100), '0, 1'b1}});
    rows.push_back('{'{pvp_pkg::WORD_MAX, pvp_pkg::WORD_MIN, '0}, 1'b1,
                     '{pvp_pkg::WORD_MAX, pvp_pkg::WORD_MIN, '0, 1'b1}});
    rows.push_back('{'{pvp_pkg::WORD_MAX, pvp_pkg::WORD_MIN, pvp_pkg::word_t'(1)}, 1'b1,
                     '{pvp_pkg::WORD_MAX, pvp_pkg::WORD_MIN, pvp_pkg::word_t'(1), 1'b0}});
    rows.push_back('{'{pvp_pkg::WORD_MAX, pvp_pkg::WORD_MIN, pvp_pkg::word_t'(-1)}, 1'b1,
                     '{pvp_pkg::WORD_MIN, pvp_pkg::WORD_MAX, pvp_pkg::word_t'(-1), 1'b0}});
    rows.push_back('{'{'0, '0, pvp_pkg::WORD_MAX}, 1'b1,
                     '{'0, '0, pvp_pkg::WORD_MAX, 1'b0}});
    rows.push_back('{'{'0, '0, pvp_pkg::WORD_MIN}, 1'b1,
                     '{'0, '0, pvp_pkg::WORD_MIN, 1'b0}});
    rows.push_back('{'{pvp_pkg::word_t'(1), pvp_pkg::word_t'(-1),
                       pvp_pkg::word_t'(2 * ONE_Q)}, 1'b0, '0});
    rows.push_back('{'{pvp_pkg::word_t'(3), pvp_pkg::word_t'(-3),
                       pvp_pkg::word_t'(2 * ONE_Q)}, 1'b0, '0});
    rows.push_back('{'{pvp_pkg::WORD_MAX, pvp_pkg::WORD_MAX, pvp_pkg::WORD_MAX},
                     1'b0, '0});
    rows.push_back('{'{pvp_pkg::WORD_MIN, pvp_pkg::WORD_MIN, pvp_pkg::WORD_MIN},
                     1'b0, '0});
    rows.push_back('{'{pvp_pkg::WORD_MIN, pvp_pkg::WORD_MAX, pvp_pkg::WORD_MIN},
                     1'b0, '0});
    rows.push_back('{'{pvp_pkg::word_t'(2 * ONE_Q), pvp_pkg::word_t'(-3 * ONE_Q),
                       pvp_pkg::word_t'(4 * ONE_Q)}, 1'b0, '0});
    rows.push_back('{'{pvp_pkg::word_t'(24'h5A5A5A), pvp_pkg::word_t'(24'hA5A5A5),
                       pvp_pkg::word_t'(24'h0F0F0F)}, 1'b0, '0});

    settings.push_back('{pvp_pkg::WORD_MAX, pvp_pkg::WORD_MIN, pvp_pkg::WORD_MAX,
                         pvp_pkg::WORD_MIN});
    settings.push_back('{pvp_pkg::WORD_MIN, pvp_pkg::WORD_MAX, pvp_pkg::WORD_MIN,
                         pvp_pkg::WORD_MAX});
    settings.push_back('{'0, '0, '0, '0});
    settings.push_back('{pvp_pkg::word_t'(85133), pvp_pkg::word_t'(113512),
                         pvp_pkg::word_t'(65602), pvp_pkg::word_t'(-6560)});
    settings.push_back('{rand_word(), rand_word(), rand_word(), rand_word()});
    settings.push_back('{pvp_pkg::word_t'($urandom), pvp_pkg::word_t'($urandom),
                         pvp_pkg::word_t'($urandom), pvp_pkg::word_t'($urandom)});
    settings.push_back('{pvp_pkg::ONE_FIX, pvp_pkg::ONE_FIX, pvp_pkg::ONE_FIX, '0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      drive_vertex(rows[i].vertex,
                   rows[i].typed ? rows[i].want : project_vertex(rows[i].vertex));
    drain();

    foreach (settings[s]) begin
      load_setting(settings[s]);
      idle_pct = (s % 3 == 0) ? 0 : (s % 3 == 1) ? 72 : 13;
      repeat (RANDOM_PER_SETTING) begin
        v = '{rand_word(), rand_word(), rand_word()};
        drive_vertex(v, project_vertex(v));
      end
      drain();
    end

    repeat (pvp_pkg::LATENCY + 4) @(posedge clk);
    mismatch_count += pending_projections.size();

    $display("sent %0d vertices under reset and %0d loaded register settings",
             vertices_sent, settings_used);
    $display("checked %0d results, %0d with w at zero, %0d mismatches",
             results_seen, w_zero_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
